### rtl/rmpu_pkg.sv
// Shared constants, types and the quarter-sine gain table of the panner unit.
package rmpu_pkg;

	localparam int CHANNELS         = 8;
	localparam int INPUT_LANES      = 8;
	localparam int LANES            = (CHANNELS < INPUT_LANES) ? CHANNELS : INPUT_LANES;
	localparam int CHAN_IDX_W       = $clog2(LANES);
	localparam int SAMPLE_BITS      = 24;
	localparam int FRAC_BITS        = 16;
	localparam int INT_BITS         = 3;
	localparam int POS_BITS         = FRAC_BITS + INT_BITS;
	localparam int EXTRA_BITS       = 20;
	localparam int ACC_BITS         = POS_BITS + EXTRA_BITS;
	localparam int STEP_BITS        = ACC_BITS + 1;
	localparam int GAIN_TABLE_DEPTH = 256;
	localparam int LOG_DEPTH        = $clog2(GAIN_TABLE_DEPTH);
	localparam int TAB_IDX_W        = LOG_DEPTH + 1;
	localparam int TAB_W            = 16;
	localparam int GAIN_W           = TAB_W + 1;
	localparam int GAIN_SHIFT       = 15;
	localparam int PROD_W           = SAMPLE_BITS + GAIN_W + 1;
	localparam int SUM_W            = PROD_W + 1;
	localparam int CNT_W            = 4;
	localparam int RAMP_W           = 20;
	localparam int DIV_STEPS        = STEP_BITS;
	localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
	localparam int ADDR_W           = 3;
	localparam int DATA_W           = 32;

	localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RESET = CNT_W'(2);
	localparam logic [RAMP_W-1:0] RAMP_SAMPLES_RESET  = RAMP_W'(441);

	// register index, taken from paddr[2]
	localparam logic REG_CHANNEL_COUNT = 1'b0;
	localparam logic REG_RAMP_SAMPLES  = 1'b1;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// Taylor series denominators (2n)(2n+1) for n = 1..12
	localparam longint TAYLOR_DEN [12] = '{
		64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
		64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
	};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [TAB_W-1:0] sine_tab_t [0:GAIN_TABLE_DEPTH];

	typedef struct packed {
		logic load;
		logic look;
		logic gain;
		logic mul;
		logic out_wr;
		logic tgt_jump;
		logic tgt_ramp;
		logic div_step;
		logic div_fin;
	} rmpu_cmd_t;

	typedef struct packed {
		logic tgt_same;
		logic ramp_zero;
		logic out_busy;
	} rmpu_stat_t;

	// sin(pi/2 * k / depth) in Q15, by integer Taylor series
	function automatic sine_tab_t build_sine_table();
		sine_tab_t tab;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint g;
		for (int k = 0; k <= GAIN_TABLE_DEPTH; k++) begin
			x = (HALF_PI_Q30 * longint'(k)) / GAIN_TABLE_DEPTH;
			x2 = (x * x) >>> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * x2) >>> 30) / TAYLOR_DEN[n - 1];
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			g = (sum + (64'sd1 <<< 14)) >>> 15;
			if (g > 32768) begin
				g = 32768;
			end
			tab[k] = TAB_W'(g);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

### rtl/rmpu_regs.sv
// Configuration register file of the panner unit, APB-style access.
module rmpu_regs import rmpu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [CNT_W-1:0]  channel_count,
	output logic [RAMP_W-1:0] ramp_samples
);

	logic [CNT_W-1:0]  channel_count_q;
	logic [RAMP_W-1:0] ramp_samples_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RESET;
			ramp_samples_q  <= RAMP_SAMPLES_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[CNT_W-1:0];
				REG_RAMP_SAMPLES:  ramp_samples_q  <= pwdata[RAMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CHANNEL_COUNT: prdata = DATA_W'(channel_count_q);
			REG_RAMP_SAMPLES:  prdata = DATA_W'(ramp_samples_q);
			default:           prdata = '0;
		endcase
	end

	assign channel_count = channel_count_q;
	assign ramp_samples  = ramp_samples_q;

endmodule

### rtl/rmpu_ctrl.sv
// Sequencing state machine of the panner unit.
module rmpu_ctrl import rmpu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_cmd,
	output logic       in_stall,
	input  rmpu_stat_t stat,
	output rmpu_cmd_t  ctl
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_T_CHK  = 4'd1;
	localparam logic [3:0] ST_T_DIV  = 4'd2;
	localparam logic [3:0] ST_T_FIN  = 4'd3;
	localparam logic [3:0] ST_F_LOOK = 4'd4;
	localparam logic [3:0] ST_F_GAIN = 4'd5;
	localparam logic [3:0] ST_F_MUL  = 4'd6;
	localparam logic [3:0] ST_F_OUT  = 4'd7;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [3:0]           state_q;
	logic [3:0]           state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = in_cmd ? ST_T_CHK : ST_F_LOOK;
				end
			end
			ST_T_CHK: begin
				if (stat.tgt_same) begin
					state_d = ST_IDLE;
				end else if (stat.ramp_zero) begin
					ctl.tgt_jump = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					ctl.tgt_ramp = 1'b1;
					state_d      = ST_T_DIV;
				end
			end
			ST_T_DIV: begin
				ctl.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_T_FIN;
				end
			end
			ST_T_FIN: begin
				ctl.div_fin = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_F_LOOK: begin
				ctl.look = 1'b1;
				state_d  = ST_F_GAIN;
			end
			ST_F_GAIN: begin
				ctl.gain = 1'b1;
				state_d  = ST_F_MUL;
			end
			ST_F_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_F_OUT;
			end
			ST_F_OUT: begin
				if (!stat.out_busy) begin
					ctl.out_wr = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.tgt_ramp) begin
				div_cnt_q <= '0;
			end else if (ctl.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

endmodule

### rtl/rmpu_dpath.sv
// Datapath of the panner unit: position state, gain lookup, mix and step divider.
module rmpu_dpath import rmpu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rmpu_cmd_t               ctl,
	output rmpu_stat_t              stat,
	input  logic [CNT_W-1:0]        channel_count,
	input  logic [RAMP_W-1:0]       ramp_samples,
	input  logic [POS_BITS-1:0]     target_position,
	input  sample_t                 samples [LANES],
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                    ramp_active,
	output logic                    out_valid,
	input  logic                    out_stall
);

	localparam int SUB_BITS = FRAC_BITS - LOG_DEPTH;
	localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [TAB_IDX_W-1:0] TAB_LAST = TAB_IDX_W'(GAIN_TABLE_DEPTH);
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (GAIN_SHIFT - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;

	// held input item
	logic [POS_BITS-1:0] target_q;
	sample_t             samples_q [LANES];

	// pan state
	logic [POS_BITS-1:0]  goal_q;
	logic [ACC_BITS-1:0]  acc_q;
	logic [STEP_BITS-1:0] step_q;
	logic [RAMP_W-1:0]    frames_q;

	// divider
	logic [STEP_BITS-1:0] quo_q;
	logic [RAMP_W-1:0]    rem_q;
	logic [RAMP_W-1:0]    dsr_q;
	logic                 neg_q;

	// frame pipeline
	logic [TAB_W-1:0]     a1_s1, b1_s1, a2_s1, b2_s1;
	logic [FRAC_BITS-1:0] f1_s1, f2_s1;
	sample_t              s1_s1, s2_s1, s1_s2, s2_s2;
	logic [GAIN_W-1:0]    g1_s2, g2_s2;
	logic signed [PROD_W-1:0] p1_s3, p2_s3;

	logic                 out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                 ramp_active_q;

	// effective channel count and clamped target
	logic [CNT_W-1:0]      chans;
	logic [CHAN_IDX_W-1:0] last_ch;
	logic [POS_BITS-1:0]   top_pos;
	logic [POS_BITS-1:0]   tgt_clamped;

	always_comb begin
		chans = channel_count;
		if (channel_count < CNT_W'(2)) begin
			chans = CNT_W'(2);
		end else if (channel_count > CNT_W'(LANES)) begin
			chans = CNT_W'(LANES);
		end
	end

	assign last_ch     = CHAN_IDX_W'(chans - 1'b1);
	assign top_pos     = POS_BITS'(last_ch) << FRAC_BITS;
	assign tgt_clamped = (target_q > top_pos) ? top_pos : target_q;

	assign stat.tgt_same  = (tgt_clamped == goal_q);
	assign stat.ramp_zero = (ramp_samples == '0);
	assign stat.out_busy  = out_valid_q && out_stall;

	// lookup addresses from the current position
	logic [POS_BITS-1:0]   cur_pos;
	logic [INT_BITS-1:0]   ip;
	logic [FRAC_BITS:0]    frac1, frac2;
	logic [TAB_IDX_W-1:0]  idx1, idx2, nidx1, nidx2;
	logic [CHAN_IDX_W-1:0] c1, c2;
	logic [INT_BITS:0]     ip_next;

	assign cur_pos = acc_q[ACC_BITS-1:EXTRA_BITS];
	assign ip      = cur_pos[POS_BITS-1:FRAC_BITS];
	assign frac2   = {1'b0, cur_pos[FRAC_BITS-1:0]};
	assign frac1   = FRAC_ONE - frac2;
	assign idx1    = frac1[FRAC_BITS:SUB_BITS];
	assign idx2    = frac2[FRAC_BITS:SUB_BITS];
	assign nidx1   = (idx1 == TAB_LAST) ? idx1 : idx1 + 1'b1;
	assign nidx2   = (idx2 == TAB_LAST) ? idx2 : idx2 + 1'b1;
	assign ip_next = {1'b0, ip} + 1'b1;
	assign c1      = (CHAN_IDX_W'(ip) < last_ch) ? CHAN_IDX_W'(ip) : last_ch;
	assign c2      = (ip_next < (INT_BITS + 1)'(last_ch)) ? CHAN_IDX_W'(ip_next) : last_ch;

	// interpolated gains
	logic signed [TAB_W:0]        d1, d2;
	logic signed [2*TAB_W+1:0]    m1, m2;
	logic signed [2*TAB_W+1:0]    gi1, gi2;

	assign d1  = $signed({1'b0, b1_s1}) - $signed({1'b0, a1_s1});
	assign d2  = $signed({1'b0, b2_s1}) - $signed({1'b0, a2_s1});
	assign m1  = d1 * $signed({1'b0, f1_s1});
	assign m2  = d2 * $signed({1'b0, f2_s1});
	assign gi1 = $signed((2*TAB_W+2)'(a1_s1)) + (m1 >>> FRAC_BITS);
	assign gi2 = $signed((2*TAB_W+2)'(a2_s1)) + (m2 >>> FRAC_BITS);

	// mix, round and saturate
	logic signed [SUM_W-1:0] mix_sum, mix_sh;
	logic signed [SAMPLE_BITS-1:0] mix_sat;

	assign mix_sum = SUM_W'(p1_s3) + SUM_W'(p2_s3) + ROUND_HALF;
	assign mix_sh  = mix_sum >>> GAIN_SHIFT;
	always_comb begin
		if (mix_sh > SAT_HI) begin
			mix_sat = SAMPLE_BITS'(SAT_HI);
		end else if (mix_sh < SAT_LO) begin
			mix_sat = SAMPLE_BITS'(SAT_LO);
		end else begin
			mix_sat = mix_sh[SAMPLE_BITS-1:0];
		end
	end

	// ramp numerator and position advance
	logic signed [STEP_BITS-1:0] num;
	logic signed [STEP_BITS:0]   acc_next;
	logic [RAMP_W:0]             rem_sh;
	logic                        rem_ge;

	assign num      = $signed({1'b0, tgt_clamped, {EXTRA_BITS{1'b0}}}) - $signed({1'b0, acc_q});
	assign acc_next = $signed({2'b0, acc_q}) + $signed({step_q[STEP_BITS-1], step_q});
	assign rem_sh   = {rem_q, quo_q[STEP_BITS-1]};
	assign rem_ge   = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			target_q <= target_position;
			for (int i = 0; i < LANES; i++) begin
				samples_q[i] <= samples[i];
			end
		end
		if (ctl.look) begin
			a1_s1 <= SINE_TABLE[idx1];
			b1_s1 <= SINE_TABLE[nidx1];
			a2_s1 <= SINE_TABLE[idx2];
			b2_s1 <= SINE_TABLE[nidx2];
			f1_s1 <= {frac1[SUB_BITS-1:0], {LOG_DEPTH{1'b0}}};
			f2_s1 <= {frac2[SUB_BITS-1:0], {LOG_DEPTH{1'b0}}};
			s1_s1 <= samples_q[c1];
			s2_s1 <= samples_q[c2];
		end
		if (ctl.gain) begin
			g1_s2 <= gi1[GAIN_W-1:0];
			g2_s2 <= gi2[GAIN_W-1:0];
			s1_s2 <= s1_s1;
			s2_s2 <= s2_s1;
		end
		if (ctl.mul) begin
			p1_s3 <= s1_s2 * $signed({1'b0, g1_s2});
			p2_s3 <= s2_s2 * $signed({1'b0, g2_s2});
		end
		if (ctl.out_wr) begin
			out_sample_q  <= mix_sat;
			ramp_active_q <= (frames_q != '0);
		end
		if (ctl.tgt_ramp) begin
			neg_q <= num[STEP_BITS-1];
			quo_q <= num[STEP_BITS-1] ? STEP_BITS'(-num) : STEP_BITS'(num);
			rem_q <= '0;
			dsr_q <= ramp_samples;
		end else if (ctl.div_step) begin
			quo_q <= {quo_q[STEP_BITS-2:0], rem_ge};
			rem_q <= rem_ge ? RAMP_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[RAMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q      <= '0;
			acc_q       <= '0;
			step_q      <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.out_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (ctl.tgt_jump) begin
				goal_q   <= tgt_clamped;
				acc_q    <= {tgt_clamped, {EXTRA_BITS{1'b0}}};
				step_q   <= '0;
				frames_q <= '0;
			end else if (ctl.tgt_ramp) begin
				goal_q   <= tgt_clamped;
				frames_q <= ramp_samples;
			end else if (ctl.div_fin) begin
				step_q <= neg_q ? -quo_q : quo_q;
			end else if (ctl.out_wr && frames_q != '0) begin
				frames_q <= frames_q - 1'b1;
				if (frames_q == RAMP_W'(1)) begin
					acc_q  <= {goal_q, {EXTRA_BITS{1'b0}}};
					step_q <= '0;
				end else if (acc_next < 0) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_next[ACC_BITS-1:0];
				end
			end
		end
	end

	assign out_sample  = out_sample_q;
	assign ramp_active = ramp_active_q;
	assign out_valid   = out_valid_q;

endmodule

### rtl/ramped_multichannel_panner_unit.sv
// Top level of the ramped multichannel equal-power panner unit.
// Usage:
//   Input channel (in_valid / in_stall) carries one item per handshake: a
//   sample frame (cmd = 0, sample_0..sample_7) or a new pan target (cmd = 1,
//   target_position, unsigned Q3.16). A frame yields exactly one result on
//   the output channel (out_valid / out_stall); a target yields none.
//   A frame passes lookup, gain interpolation, multiply and mix on its way
//   to the result register, and the next item waits until the frame is done.
//   A target that moves the goal with a non-zero ramp runs through the
//   restoring step divider, which retires one quotient bit per cycle
//   over a 40-bit numerator; an unchanged target and a jump
//   (ramp_samples = 0) end at the check. One item is in work at a time.
//   The result sits in an output register: the next item is accepted while
//   a result waits, and such an item, if a frame, holds in its final step until the
//   receiver drops out_stall.
//   Reset clears the pan position, goal, step and ramp count, sets
//   channel_count to 2 and ramp_samples to 441, and empties the output.
//   Registers (APB, byte address 4*i): 0 channel_count, 1 ramp_samples;
//   write them only while the unit is idle.
module ramped_multichannel_panner_unit import rmpu_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [POS_BITS-1:0]           target_position,
	input  logic signed [SAMPLE_BITS-1:0] sample_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_3,
	input  logic signed [SAMPLE_BITS-1:0] sample_4,
	input  logic signed [SAMPLE_BITS-1:0] sample_5,
	input  logic signed [SAMPLE_BITS-1:0] sample_6,
	input  logic signed [SAMPLE_BITS-1:0] sample_7,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          ramp_active
);

	logic [CNT_W-1:0]  channel_count;
	logic [RAMP_W-1:0] ramp_samples;
	rmpu_cmd_t         ctl;
	rmpu_stat_t        stat;
	sample_t           lanes [LANES];
	sample_t           ports [INPUT_LANES];

	// gather the sample ports into lanes; lanes beyond the build are dropped
	assign ports[0] = sample_0;
	assign ports[1] = sample_1;
	assign ports[2] = sample_2;
	assign ports[3] = sample_3;
	assign ports[4] = sample_4;
	assign ports[5] = sample_5;
	assign ports[6] = sample_6;
	assign ports[7] = sample_7;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lanes[i] = ports[i];
		end
	end

	rmpu_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.channel_count (channel_count),
		.ramp_samples  (ramp_samples)
	);

	rmpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	rmpu_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.channel_count   (channel_count),
		.ramp_samples    (ramp_samples),
		.target_position (target_position),
		.samples         (lanes),
		.out_sample      (out_sample),
		.ramp_active     (ramp_active),
		.out_valid       (out_valid),
		.out_stall       (out_stall)
	);

	// one item at a time: an accepted item closes the input for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item was in work");

	// a target item raises no result from its check state
	a_target_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cmd) |=> ##1 !$rose(out_valid))
		else $error("result raised after a target item");

	// a new result appears only when an item was in work
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without an item in work");

endmodule
